// ===== rtl/isotp_pkg.sv =====
// Shared types, codes and tables for the ISO-8601 timestamp parser.
`timescale 1ns / 1ps

package isotp_pkg;

  localparam int QUEUE_DEPTH_DEF = 2;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FORMAT   = 2'd1,
    ST_RANGE    = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    TP_START = 2'd0,
    TP_DOT   = 2'd1,
    TP_FRAC  = 2'd2,
    TP_ZONE  = 2'd3
  } tail_phase_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_ERA,
    BK_YOE,
    BK_DAYS,
    BK_SECS,
    BK_CHK,
    BK_MHI,
    BK_LOAD
  } back_state_t;

  // One parsed string, handed from the front to the back.
  typedef struct packed {
    status_t      status;
    logic [13:0]  year;
    logic [3:0]   month;
    logic [4:0]   day;
    logic [4:0]   hour;
    logic [5:0]   minute;
    logic [5:0]   second;
    logic [29:0]  frac;
  } rec_t;

  function automatic logic [26:0] frac_scale(input logic [3:0] idx);
    logic [26:0] s;
    case (idx)
      4'd0: s = 27'd100000000;
      4'd1: s = 27'd10000000;
      4'd2: s = 27'd1000000;
      4'd3: s = 27'd100000;
      4'd4: s = 27'd10000;
      4'd5: s = 27'd1000;
      4'd6: s = 27'd100;
      4'd7: s = 27'd10;
      4'd8: s = 27'd1;
      default: s = 27'd0;
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/iso8601_timestamp_parser_core.sv =====
// Top level of the ISO-8601 UTC timestamp to Unix nanoseconds parser.
`timescale 1ns / 1ps

// Input channel: one text character per beat (ch, last) on in_valid/in_ready;
// last marks the final character of a timestamp string.
// Output channel: one beat per string (status, unix_nanos) on
// out_valid/out_ready; unix_nanos is zero unless status is ok.
// Throughput: one character per cycle on average while strings are at least
// two characters long and out_ready stays high. An ok string runs through
// the arithmetic steps of the back end and an error string skips them, overlapped
// with the next string's characters through a QUEUE_DEPTH-entry record queue.
// With the back end idle, an ok result passes, once the last character is taken,
// through the pop, six arithmetic steps and the output register; an error
// result goes from the pop straight to the output register.
// in_ready drops only when the record queue is full; the back end holds its
// result in the output register while out_ready is low and then stops
// popping, so a stalled receiver backs up into the queue and then the input.
// Reset clears the parser state, the queue and the output valid; the block
// is ready in the first cycle after reset.
module iso8601_timestamp_parser_core import isotp_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         ch,
  input  logic               last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic signed [63:0] unix_nanos
);

  logic push, q_full, pop, q_empty;
  rec_t push_rec, q_rec;

  isotp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .ch       (ch),
    .last     (last),
    .push     (push),
    .push_rec (push_rec),
    .q_full   (q_full)
  );

  isotp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (push_rec),
    .full  (q_full),
    .pop   (pop),
    .rdata (q_rec),
    .empty (q_empty)
  );

  isotp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .rec        (q_rec),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .unix_nanos (unix_nanos)
  );

endmodule

// ===== rtl/isotp_front.sv =====
// Front end: fixed-field/tail parsing, one beat per cycle unless q_full.
`timescale 1ns / 1ps

module isotp_front import isotp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] ch,
  input  logic       last,
  output logic       push,
  output rec_t       push_rec,
  input  logic       q_full
);

  logic [4:0]  position, position_next;
  logic [13:0] year_acc, year_acc_next;
  logic [6:0]  month_acc, month_acc_next;
  logic [6:0]  day_acc, day_acc_next;
  logic [6:0]  hour_acc, hour_acc_next;
  logic [6:0]  minute_acc, minute_acc_next;
  logic [6:0]  second_acc, second_acc_next;
  logic [29:0] fraction_acc, fraction_acc_next;
  logic [3:0]  fraction_count, fraction_count_next;
  tail_phase_t tail_phase, tail_phase_next;
  logic        format_bad, format_bad_next;
  logic        tail_bad, tail_bad_next;

  logic        accept;
  logic        dig;
  logic        zone;
  logic [3:0]  dv;
  logic [30:0] frac_prod;
  status_t     st;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign dig      = (ch >= 8'd48) && (ch <= 8'd57);
  assign zone     = (ch == 8'd90) || (ch == 8'd122);
  assign dv       = ch[3:0];
  assign frac_prod = {27'b0, dv} * {4'b0, frac_scale(fraction_count)};

  always_comb begin
    position_next       = position;
    year_acc_next       = year_acc;
    month_acc_next      = month_acc;
    day_acc_next        = day_acc;
    hour_acc_next       = hour_acc;
    minute_acc_next     = minute_acc;
    second_acc_next     = second_acc;
    fraction_acc_next   = fraction_acc;
    fraction_count_next = fraction_count;
    tail_phase_next     = tail_phase;
    format_bad_next     = format_bad;
    tail_bad_next       = tail_bad;
    if (position < 5'd19) begin
      position_next = position + 5'd1;
      case (position)
        5'd0, 5'd1, 5'd2, 5'd3: begin
          if (dig) year_acc_next = 14'(year_acc * 14'd10) + 14'(dv);
          else format_bad_next = 1'b1;
        end
        5'd5, 5'd6: begin
          if (dig) month_acc_next = 7'(month_acc * 7'd10) + 7'(dv);
          else format_bad_next = 1'b1;
        end
        5'd8, 5'd9: begin
          if (dig) day_acc_next = 7'(day_acc * 7'd10) + 7'(dv);
          else format_bad_next = 1'b1;
        end
        5'd11, 5'd12: begin
          if (dig) hour_acc_next = 7'(hour_acc * 7'd10) + 7'(dv);
          else format_bad_next = 1'b1;
        end
        5'd14, 5'd15: begin
          if (dig) minute_acc_next = 7'(minute_acc * 7'd10) + 7'(dv);
          else format_bad_next = 1'b1;
        end
        5'd17, 5'd18: begin
          if (dig) second_acc_next = 7'(second_acc * 7'd10) + 7'(dv);
          else format_bad_next = 1'b1;
        end
        5'd4, 5'd7: begin
          if (ch != 8'd45) format_bad_next = 1'b1;
        end
        5'd10: begin
          if (ch != 8'd84 && ch != 8'd116 && ch != 8'd32) format_bad_next = 1'b1;
        end
        default: begin
          if (ch != 8'd58) format_bad_next = 1'b1;
        end
      endcase
    end else if (!tail_bad) begin
      case (tail_phase)
        TP_START: begin
          if (ch == 8'd46) tail_phase_next = TP_DOT;
          else if (zone) tail_phase_next = TP_ZONE;
          else tail_bad_next = 1'b1;
        end
        TP_DOT, TP_FRAC: begin
          if (dig) begin
            if (fraction_count < 4'd9) begin
              fraction_acc_next   = fraction_acc + frac_prod[29:0];
              fraction_count_next = fraction_count + 4'd1;
            end
            tail_phase_next = TP_FRAC;
          end else if (zone && tail_phase == TP_FRAC) begin
            tail_phase_next = TP_ZONE;
          end else begin
            tail_bad_next = 1'b1;
          end
        end
        default: tail_bad_next = 1'b1;
      endcase
    end
  end

  always_comb begin
    if (position_next < 5'd19 || format_bad_next) begin
      st = ST_FORMAT;
    end else if (month_acc_next < 7'd1 || month_acc_next > 7'd12 ||
                 day_acc_next < 7'd1 || day_acc_next > 7'd31 ||
                 hour_acc_next > 7'd23 || minute_acc_next > 7'd59 ||
                 second_acc_next > 7'd60) begin
      st = ST_RANGE;
    end else if (tail_bad_next || tail_phase_next == TP_DOT) begin
      st = ST_FORMAT;
    end else begin
      st = ST_OK;
    end
  end

  assign push = accept && last;

  always_comb begin
    push_rec.status = st;
    push_rec.year   = year_acc_next;
    push_rec.month  = month_acc_next[3:0];
    push_rec.day    = day_acc_next[4:0];
    push_rec.hour   = hour_acc_next[4:0];
    push_rec.minute = minute_acc_next[5:0];
    push_rec.second = second_acc_next[5:0];
    push_rec.frac   = fraction_acc_next;
  end

  always_ff @(posedge clk) begin
    if (rst || push) begin
      position       <= '0;
      year_acc       <= '0;
      month_acc      <= '0;
      day_acc        <= '0;
      hour_acc       <= '0;
      minute_acc     <= '0;
      second_acc     <= '0;
      fraction_acc   <= '0;
      fraction_count <= '0;
      tail_phase     <= TP_START;
      format_bad     <= 1'b0;
      tail_bad       <= 1'b0;
    end else if (accept) begin
      position       <= position_next;
      year_acc       <= year_acc_next;
      month_acc      <= month_acc_next;
      day_acc        <= day_acc_next;
      hour_acc       <= hour_acc_next;
      minute_acc     <= minute_acc_next;
      second_acc     <= second_acc_next;
      fraction_acc   <= fraction_acc_next;
      fraction_count <= fraction_count_next;
      tail_phase     <= tail_phase_next;
      format_bad     <= format_bad_next;
      tail_bad       <= tail_bad_next;
    end
  end

endmodule

// ===== rtl/isotp_queue.sv =====
// Short record queue between the parser front and the date back end.
`timescale 1ns / 1ps

module isotp_queue import isotp_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  rec_t wdata,
  output logic full,
  input  logic pop,
  output rec_t rdata,
  output logic empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  rec_t          mem [DEPTH];
  logic [PW-1:0] wptr, rptr;
  logic [CW-1:0] count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + PW'(1);
      if (pop)  rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + PW'(1);
      if (push && !pop) count <= count + CW'(1);
      else if (pop && !push) count <= count - CW'(1);
    end
  end

endmodule

// ===== rtl/isotp_back.sv =====
// Back end: civil day count, seconds, overflow check and nanosecond scaling.
`timescale 1ns / 1ps

module isotp_back import isotp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  rec_t               rec,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic signed [63:0] unix_nanos
);

  back_state_t state, state_next;

  status_t            st;
  logic [13:0]        year;
  logic [3:0]         month;
  logic [4:0]         day;
  logic [4:0]         hour;
  logic [5:0]         minute;
  logic [5:0]         second;
  logic [29:0]        frac;
  logic [13:0]        yv;
  logic               yneg;
  logic signed [5:0]  era;
  logic [8:0]         doy;
  logic [8:0]         yoe;
  logic signed [23:0] days;
  logic signed [39:0] secs;
  logic [46:0]        plo;
  logic signed [47:0] phi;
  logic [47:0]        plf;

  logic               load;
  logic               ovf;
  logic signed [14:0] y_c;
  logic [26:0]        era_prod;
  logic [3:0]         mp;
  logic [13:0]        e400;
  logic [1:0]         q100;
  logic [17:0]        doe;
  logic signed [31:0] days32;
  logic signed [39:0] secs_c;
  logic [63:0]        sum;

  function automatic logic [8:0] mstart(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd0:  r = 9'd0;
      4'd1:  r = 9'd31;
      4'd2:  r = 9'd61;
      4'd3:  r = 9'd92;
      4'd4:  r = 9'd122;
      4'd5:  r = 9'd153;
      4'd6:  r = 9'd184;
      4'd7:  r = 9'd214;
      4'd8:  r = 9'd245;
      4'd9:  r = 9'd275;
      4'd10: r = 9'd306;
      4'd11: r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // march-based year; floor(y/400) by reciprocal, exact for y < 16384
  assign y_c      = $signed({1'b0, year}) - ((month <= 4'd2) ? 15'sd1 : 15'sd0);
  assign era_prod = y_c[13:0] * 13'd5243;
  assign mp       = (month > 4'd2) ? month - 4'd3 : month + 4'd9;
  assign e400     = {9'b0, era[4:0]} * 14'd400;
  assign q100     = (yoe >= 9'd300) ? 2'd3 : (yoe >= 9'd200) ? 2'd2 :
                    (yoe >= 9'd100) ? 2'd1 : 2'd0;
  assign doe      = 18'(yoe) * 18'd365 + 18'(yoe[8:2]) - 18'(q100) + 18'(doy);
  assign days32   = 32'(era) * 32'sd146097 + $signed({14'b0, doe}) - 32'sd719468;
  assign secs_c   = 40'(days) * 40'sd86400 + $signed(40'(hour) * 40'd3600) +
                    $signed(40'(minute) * 40'd60) + $signed(40'(second));
  assign ovf      = (secs > 40'sd9223372036) ||
                    (secs == 40'sd9223372036 && frac > 30'd854775807) ||
                    (secs < -40'sd9223372037) ||
                    (secs == -40'sd9223372037 && frac < 30'd145224192);
  assign sum      = (64'(phi) << 17) + 64'(plf);
  assign load     = (state == BK_LOAD) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) state <= BK_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    case (state)
      BK_IDLE: begin
        if (!q_empty) begin
          pop        = 1'b1;
          state_next = (rec.status == ST_OK) ? BK_ERA : BK_LOAD;
        end
      end
      BK_ERA:  state_next = BK_YOE;
      BK_YOE:  state_next = BK_DAYS;
      BK_DAYS: state_next = BK_SECS;
      BK_SECS: state_next = BK_CHK;
      BK_CHK:  state_next = ovf ? BK_LOAD : BK_MHI;
      BK_MHI:  state_next = BK_LOAD;
      BK_LOAD: begin
        if (load) state_next = BK_IDLE;
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      BK_IDLE: begin
        if (pop) begin
          st     <= rec.status;
          year   <= rec.year;
          month  <= rec.month;
          day    <= rec.day;
          hour   <= rec.hour;
          minute <= rec.minute;
          second <= rec.second;
          frac   <= rec.frac;
        end
      end
      BK_ERA: begin
        yv   <= y_c[13:0];
        yneg <= y_c[14];
        era  <= y_c[14] ? -6'sd1 : $signed(era_prod[26:21]);
        doy  <= mstart(mp) + 9'(day) - 9'd1;
      end
      BK_YOE:  yoe  <= yneg ? 9'd399 : 9'(yv - e400);
      BK_DAYS: days <= days32[23:0];
      BK_SECS: secs <= secs_c;
      BK_CHK: begin
        plo <= secs[16:0] * 30'd1000000000;
        if (ovf) st <= ST_OVERFLOW;
      end
      BK_MHI: begin
        phi <= 48'($signed(secs[34:17])) * 48'sd1000000000;
        plf <= {1'b0, plo} + 48'(frac);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status     <= st;
      unix_nanos <= (st == ST_OK) ? $signed(sum) : 64'sd0;
    end
  end

`ifndef SYNTHESIS
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> unix_nanos == 64'sd0)
    else $error("nonzero nanos with error status");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_empty && state == BK_IDLE)
    else $error("pop from empty queue");
  a_pop_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    pop |=> state == BK_ERA || state == BK_LOAD)
    else $error("back end did not start after pop");
  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    load |=> out_valid && state == BK_IDLE)
    else $error("load did not present a result");
`endif

endmodule

// ===== tb/tb_iso8601_timestamp_parser_core.sv =====
// Self-checking testbench for the ISO-8601 timestamp parser core.
`timescale 1ns / 1ps

module tb_iso8601_timestamp_parser_core;
  import isotp_pkg::*;

  localparam int BEAT_GOAL   = 800;
  localparam int CALM_AFTER  = 700;
  localparam int CYCLE_LIMIT = 300000;
  localparam int N_DIR       = 30;

  typedef struct {
    status_t     code;
    logic [63:0] nanos;
  } stamp_result_t;

  typedef struct {
    string       text;
    bit          known;
    status_t     code;
    logic [63:0] nanos;
  } dir_row_t;

  logic               clk;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         ch = 8'd0;
  logic               last = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         status;
  logic signed [63:0] unix_nanos;

  logic [4:0]  txt_pos;
  logic [13:0] yr_acc;
  logic [6:0]  mon_acc, day_acc, hr_acc, min_acc, sec_acc;
  logic [29:0] frac_acc;
  logic [3:0]  frac_digits;
  tail_phase_t tail_st;
  bit          fixed_err, tail_err;

  stamp_result_t awaited[$];
  int errors = 0;
  int beats_sent = 0;
  int strings_sent = 0;
  int results_seen = 0;
  int by_status [4] = '{default: 0};
  int cycles = 0;
  int stall_left = 0;
  bit calm = 1'b0;

  // known rows carry the result; the rest go through the predictor
  dir_row_t dir_rows [N_DIR] = '{
    '{"1970-01-01T00:00:00Z",             1'b1, ST_OK,       64'd0},
    '{"1970-01-01 00:00:00",              1'b1, ST_OK,       64'd0},
    '{"1970-01-01t00:00:01.5z",           1'b1, ST_OK,       64'd1500000000},
    '{"1969-12-31T23:59:59.999999999",    1'b1, ST_OK,       64'hFFFF_FFFF_FFFF_FFFF},
    '{"2262-04-11T23:47:16.854775807",    1'b1, ST_OK,       64'h7FFF_FFFF_FFFF_FFFF},
    '{"2262-04-11T23:47:16.854775808",    1'b1, ST_OVERFLOW, 64'd0},
    '{"1677-09-21T00:12:43.145224192Z",   1'b1, ST_OK,       64'h8000_0000_0000_0000},
    '{"1677-09-21T00:12:43.145224191",    1'b1, ST_OVERFLOW, 64'd0},
    '{"0000-01-01T00:00:00",              1'b1, ST_OVERFLOW, 64'd0},
    '{"9999-12-31T23:59:60.99999999999Z", 1'b1, ST_OVERFLOW, 64'd0},
    '{"2024-02-29T12:34:56.123Z",         1'b0, ST_OK,       64'd0},
    '{"2000-02-31t08:00:00",              1'b0, ST_OK,       64'd0},
    '{"2016-12-31T23:59:60",              1'b0, ST_OK,       64'd0},
    '{"2024-13-01T00:00:00",              1'b1, ST_RANGE,    64'd0},
    '{"2024-00-10T00:00:00",              1'b1, ST_RANGE,    64'd0},
    '{"2024-01-32T00:00:00",              1'b1, ST_RANGE,    64'd0},
    '{"2024-01-00T24:00:00",              1'b1, ST_RANGE,    64'd0},
    '{"2024-01-01T00:60:00",              1'b1, ST_RANGE,    64'd0},
    '{"2024-01-01T00:00:61",              1'b1, ST_RANGE,    64'd0},
    '{"9999-99-99T99:99:99",              1'b1, ST_RANGE,    64'd0},
    '{"2024-01-01T00:00",                 1'b1, ST_FORMAT,   64'd0},
    '{"X",                                1'b1, ST_FORMAT,   64'd0},
    '{"2024/01-01T00:00:00",              1'b1, ST_FORMAT,   64'd0},
    '{"2024-99-01X00:00:00",              1'b1, ST_FORMAT,   64'd0},
    '{"2024-99-01T00:00:00.",             1'b1, ST_RANGE,    64'd0},
    '{"2024-01-01T00:00:00.",             1'b1, ST_FORMAT,   64'd0},
    '{"2024-01-01T00:00:00.Z",            1'b1, ST_FORMAT,   64'd0},
    '{"2024-01-01T00:00:00Zz",            1'b1, ST_FORMAT,   64'd0},
    '{"2024-01-01T00:00:00.12a",          1'b1, ST_FORMAT,   64'd0},
    '{"1970-01-01T00:00:00\377",          1'b1, ST_FORMAT,   64'd0}
  };

  iso8601_timestamp_parser_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .ch        (ch),
    .last      (last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .unix_nanos(unix_nanos)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic void clear_parse();
    txt_pos     = '0;
    yr_acc      = '0;
    mon_acc     = '0;
    day_acc     = '0;
    hr_acc      = '0;
    min_acc     = '0;
    sec_acc     = '0;
    frac_acc    = '0;
    frac_digits = '0;
    tail_st     = TP_START;
    fixed_err   = 1'b0;
    tail_err    = 1'b0;
  endfunction

  function automatic void take_fixed(input logic [7:0] c);
    logic [3:0] dv;
    dv = c[3:0];
    case (txt_pos)
      5'd0, 5'd1, 5'd2, 5'd3:
        if (is_digit(c)) yr_acc = 14'(yr_acc * 10 + dv); else fixed_err = 1'b1;
      5'd5, 5'd6:
        if (is_digit(c)) mon_acc = 7'(mon_acc * 10 + dv); else fixed_err = 1'b1;
      5'd8, 5'd9:
        if (is_digit(c)) day_acc = 7'(day_acc * 10 + dv); else fixed_err = 1'b1;
      5'd11, 5'd12:
        if (is_digit(c)) hr_acc = 7'(hr_acc * 10 + dv); else fixed_err = 1'b1;
      5'd14, 5'd15:
        if (is_digit(c)) min_acc = 7'(min_acc * 10 + dv); else fixed_err = 1'b1;
      5'd17, 5'd18:
        if (is_digit(c)) sec_acc = 7'(sec_acc * 10 + dv); else fixed_err = 1'b1;
      5'd4, 5'd7:
        if (c != "-") fixed_err = 1'b1;
      5'd10:
        if (c != "T" && c != "t" && c != " ") fixed_err = 1'b1;
      default:
        if (c != ":") fixed_err = 1'b1;
    endcase
  endfunction

  function automatic void take_tail(input logic [7:0] c);
    bit          zone;
    int unsigned weight;
    zone = (c == "Z" || c == "z");
    if (tail_err) return;
    case (tail_st)
      TP_START: begin
        if (c == ".") tail_st = TP_DOT;
        else if (zone) tail_st = TP_ZONE;
        else tail_err = 1'b1;
      end
      TP_DOT, TP_FRAC: begin
        if (is_digit(c)) begin
          // digits past the ninth are dropped
          if (frac_digits < 9) begin
            weight = 1;
            repeat (8 - frac_digits) weight = weight * 10;
            frac_acc = 30'(frac_acc + c[3:0] * weight);
            frac_digits = frac_digits + 4'd1;
          end
          tail_st = TP_FRAC;
        end else if (zone && tail_st == TP_FRAC) begin
          tail_st = TP_ZONE;
        end else begin
          tail_err = 1'b1;
        end
      end
      default: tail_err = 1'b1;
    endcase
  endfunction

  // proleptic Gregorian day count relative to 1970-01-01
  function automatic longint days_since_epoch(input longint year, input int m, input int d);
    longint y, era, yoe, doy, doe;
    y   = year - ((m <= 2) ? 1 : 0);
    era = ((y >= 0) ? y : y - 399) / 400;
    yoe = y - era * 400;
    doy = (153 * ((m > 2) ? m - 3 : m + 9) + 2) / 5 + d - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    return era * 146097 + doe - 719468;
  endfunction

  function automatic bit parse_char(input logic [7:0] c, input bit fin,
                                    output stamp_result_t res);
    longint secs;
    int     mo, dd, hh, mm, ss;
    bit     ovf;
    res.code  = ST_OK;
    res.nanos = '0;
    if (txt_pos < 19) begin
      take_fixed(c);
      txt_pos = txt_pos + 5'd1;
    end else begin
      take_tail(c);
    end
    if (!fin) return 1'b0;
    mo = int'(mon_acc);
    dd = int'(day_acc);
    hh = int'(hr_acc);
    mm = int'(min_acc);
    ss = int'(sec_acc);
    if (txt_pos < 19 || fixed_err) begin
      res.code = ST_FORMAT;
    end else if (mo < 1 || mo > 12 || dd < 1 || dd > 31 || hh > 23 || mm > 59 || ss > 60) begin
      res.code = ST_RANGE;
    end else if (tail_err || tail_st == TP_DOT) begin
      res.code = ST_FORMAT;
    end else begin
      secs = days_since_epoch(longint'(yr_acc), mo, dd) * 64'sd86400 +
             longint'(hh) * 3600 + longint'(mm) * 60 + longint'(ss);
      ovf = (secs > 64'sd9223372036) ||
            (secs == 64'sd9223372036 && frac_acc > 30'd854775807) ||
            (secs < -64'sd9223372037) ||
            (secs == -64'sd9223372037 && frac_acc < 30'd145224192);
      if (ovf) res.code = ST_OVERFLOW;
      else res.nanos = secs * 64'sd1000000000 + longint'(frac_acc);
    end
    clear_parse();
    return 1'b1;
  endfunction

  function automatic void to_bytes(input string s, output logic [7:0] txt[$]);
    txt = {};
    for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
  endfunction

  function automatic void random_stamp(output logic [7:0] txt[$]);
    string s, sep, zone;
    int    kind, yr, mo, dd, hh, mm, ss, n, idx;
    kind = $urandom_range(0, 99);
    case ($urandom_range(0, 3))
      0: yr = $urandom_range(0, 9999);
      1: yr = $urandom_range(1900, 2100);
      2: yr = $urandom_range(1676, 1678);
      default: yr = $urandom_range(2261, 2263);
    endcase
    mo = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 12);
    dd = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 31);
    hh = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 23);
    mm = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 59);
    ss = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 60);
    case ($urandom_range(0, 2))
      0: sep = "T";
      1: sep = "t";
      default: sep = " ";
    endcase
    zone = $urandom_range(0, 1) ? "Z" : "z";
    s = $sformatf("%04d-%02d-%02d%s%02d:%02d:%02d", yr, mo, dd, sep, hh, mm, ss);
    case ($urandom_range(0, 5))
      0: ;
      1, 5: s = {s, zone};
      2, 3: begin
        s = {s, "."};
        n = $urandom_range(1, 12);
        repeat (n) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
        if ($urandom_range(0, 1)) s = {s, zone};
      end
      default: begin
        case ($urandom_range(0, 3))
          0: s = {s, "."};
          1: s = {s, ".", zone};
          2: s = {s, zone, zone};
          default: s = {s, ".5x"};
        endcase
      end
    endcase
    to_bytes(s, txt);
    if (kind >= 85) begin
      txt = {};
      n = $urandom_range(1, 30);
      repeat (n) txt.push_back(8'($urandom_range(0, 255)));
    end else if (kind >= 65) begin
      if ($urandom_range(0, 2) != 0) begin
        idx = $urandom_range(0, txt.size() - 1);
        txt[idx] = 8'($urandom_range(0, 255));
      end else begin
        n = $urandom_range(1, txt.size() - 1);
        while (txt.size() > n) void'(txt.pop_back());
      end
    end
  endfunction

  task automatic send_text(input logic [7:0] txt[$], input bit known, input status_t kcode,
                           input logic [63:0] knanos, input int gap_odds);
    stamp_result_t res;
    for (int i = 0; i < txt.size(); i++) begin
      if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
      in_valid <= 1'b1;
      ch       <= txt[i];
      last     <= (i == txt.size() - 1);
      do @(posedge clk); while (!in_ready);
      beats_sent++;
      if (parse_char(txt[i], i == txt.size() - 1, res)) begin
        if (known) begin
          res.code  = kcode;
          res.nanos = knanos;
        end
        awaited.push_back(res);
      end
    end
    strings_sent++;
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
  endtask

  initial begin
    logic [7:0] txt[$];
    clear_parse();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    for (int r = 0; r < N_DIR; r++) begin
      to_bytes(dir_rows[r].text, txt);
      send_text(txt, dir_rows[r].known, dir_rows[r].code, dir_rows[r].nanos, 6);
    end
    wait_for_results();
    while (beats_sent < BEAT_GOAL) begin
      if (beats_sent >= CALM_AFTER) calm = 1'b1;
      if (strings_sent == N_DIR + 4) wait_for_results();
      random_stamp(txt);
      send_text(txt, 1'b0, ST_OK, 64'd0,
                $urandom_range(0, 1) ? 0 : $urandom_range(3, 12));
    end
    wait_for_results();
    repeat (30) @(posedge clk);
    $display("Sent %0d strings as %0d character beats; %0d results came back.",
             strings_sent, beats_sent, results_seen);
    $display("Status mix: ok %0d, format %0d, range %0d, overflow %0d.",
             by_status[ST_OK], by_status[ST_FORMAT], by_status[ST_RANGE],
             by_status[ST_OVERFLOW]);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  always @(posedge clk) begin
    stamp_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (awaited.size() == 0) begin
          errors++;
          $error("result beat with nothing pending: status %0d, unix_nanos %0d",
                 status, unix_nanos);
        end else begin
          want = awaited.pop_front();
          by_status[want.code]++;
          if (status !== want.code) begin
            errors++;
            $error("status: expected %0d, got %0d", want.code, status);
          end
          if (unix_nanos !== want.nanos) begin
            errors++;
            $error("unix_nanos: expected %0d, got %0d", $signed(want.nanos), unix_nanos);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 17) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results outstanding",
               cycles, awaited.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

endmodule

// ===== files.f =====
rtl/isotp_pkg.sv
rtl/isotp_front.sv
rtl/isotp_queue.sv
rtl/isotp_back.sv
rtl/iso8601_timestamp_parser_core.sv
tb/tb_iso8601_timestamp_parser_core.sv
